### rtl/core/cse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cse_pkg;

   // Width of the internal running counts, reported in 16 bits
   localparam int COUNT_BITS = 16;
   localparam int REPORT_BITS = 16;
   localparam int CAP_BITS = 16;
   // Compare width that holds count plus expansion against capacity
   localparam int CMP_BITS = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Register indexes on the control port
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_CAPACITY = 2'd1;
   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 16'hffff;

   // Item kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // Character constants
   localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
   localparam logic [7:0] CHAR_PRINT_HI = 8'h7e;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_APOS = 8'h27;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   // One escaped item: up to four characters plus its report
   typedef struct packed {
      logic [3:0][7:0]         chars;
      logic [1:0]              last_idx;
      logic                    is_term;
      logic                    stopped;
      logic [REPORT_BITS-1:0]  consumed;
      logic [REPORT_BITS-1:0]  emitted;
   } job_type;

   // Letter of a named control escape, zero when the code has none
   function automatic logic [7:0] named_letter(input logic [7:0] c);
      logic [7:0] r;
      r = 8'h00;
      if (c < CHAR_PRINT_LO) begin
         case (c[4:0])
            5'd7:    r = "a";
            5'd8:    r = "b";
            5'd9:    r = "t";
            5'd10:   r = "n";
            5'd11:   r = "v";
            5'd12:   r = "f";
            5'd13:   r = "r";
            default: r = 8'h00;
         endcase
      end
      return r;
   endfunction

   // Low 16 bits of a count for the report
   function automatic logic [REPORT_BITS-1:0] to_report(input logic [COUNT_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[REPORT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/core/cse_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cse_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] in_byte;
   modport source (output valid, output kind, output in_byte, input ready);
   modport sink (input valid, input kind, input in_byte, output ready);
endinterface

interface cse_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_char;
   logic        run_last;
   logic        is_terminator;
   logic        stopped;
   logic [15:0] consumed_count;
   logic [15:0] out_length;
   modport source (output valid, output out_char, output run_last, output is_terminator,
                   output stopped, output consumed_count, output out_length, input ready);
   modport sink (input valid, input out_char, input run_last, input is_terminator,
                 input stopped, input consumed_count, input out_length, output ready);
endinterface

interface cse_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/cse_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cse_front (
   input  wire logic     clock,
   input  wire logic     reset,
   cse_req_if.sink       req_bus,
   cse_csr_if.sink       csr_bus,
   input  wire logic     queue_full,
   output logic          push,
   output cse_pkg::job_type push_job
);
   import cse_pkg::*;

   logic                  limit_ff, limit_in;
   logic [CAP_BITS-1:0]   cap_ff, cap_in;
   logic                  guard_ff, guard_in;
   logic                  halted_ff, halted_in;
   logic [COUNT_BITS-1:0] emitted_ff, emitted_in;
   logic [COUNT_BITS-1:0] consumed_ff, consumed_in;

   logic [7:0]            c;
   logic [7:0]            letter;
   logic                  octal_esc;
   logic [3:0][7:0]       seq;
   logic [2:0]            n;
   logic                  next_guard;
   logic                  fits;
   logic                  accept;
   logic [CMP_BITS-1:0]   need;
   logic [COUNT_BITS:0]   emit_sum;
   logic [COUNT_BITS:0]   cons_sum;
   logic [COUNT_BITS-1:0] emit_sat;
   logic [COUNT_BITS-1:0] cons_sat;

   assign req_bus.ready = !queue_full;
   assign csr_bus.ready = 1'b1;
   assign accept = req_bus.valid && !queue_full;

   // Classify the byte and build its escape sequence
   always_comb begin
      c = req_bus.in_byte;
      letter = named_letter(c);
      octal_esc = (c < CHAR_PRINT_LO) || (c > CHAR_PRINT_HI)
                  || (guard_ff && (c >= CHAR_ZERO) && (c <= CHAR_SEVEN));
      seq = '0;
      n = 3'd1;
      next_guard = 1'b0;
      if (octal_esc) begin
         seq[0] = CHAR_BSLASH;
         if (letter != 8'h00) begin
            seq[1] = letter;
            n = 3'd2;
         end else if (c[7:6] != 2'b00) begin
            seq[1] = CHAR_ZERO | {6'b0, c[7:6]};
            seq[2] = CHAR_ZERO | {5'b0, c[5:3]};
            seq[3] = CHAR_ZERO | {5'b0, c[2:0]};
            n = 3'd4;
         end else if (c[5:3] != 3'b000) begin
            seq[1] = CHAR_ZERO | {5'b0, c[5:3]};
            seq[2] = CHAR_ZERO | {5'b0, c[2:0]};
            n = 3'd3;
            next_guard = 1'b1;
         end else begin
            seq[1] = CHAR_ZERO | {5'b0, c[2:0]};
            n = 3'd2;
            next_guard = 1'b1;
         end
      end else if ((c == CHAR_DQUOTE) || (c == CHAR_APOS) || (c == CHAR_BSLASH)) begin
         seq[0] = CHAR_BSLASH;
         seq[1] = c;
         n = 3'd2;
      end else begin
         seq[0] = c;
      end
   end

   // Capacity check and saturating count updates
   always_comb begin
      need = CMP_BITS'(emitted_ff) + CMP_BITS'(n);
      fits = !limit_ff || (need < CMP_BITS'(cap_ff));
      emit_sum = (COUNT_BITS+1)'(emitted_ff) + (COUNT_BITS+1)'(n);
      cons_sum = (COUNT_BITS+1)'(consumed_ff) + (COUNT_BITS+1)'(1'b1);
      emit_sat = emit_sum[COUNT_BITS] ? COUNT_MAX : emit_sum[COUNT_BITS-1:0];
      cons_sat = cons_sum[COUNT_BITS] ? COUNT_MAX : cons_sum[COUNT_BITS-1:0];
   end

   // Next state and queued job
   always_comb begin
      guard_in = guard_ff;
      halted_in = halted_ff;
      emitted_in = emitted_ff;
      consumed_in = consumed_ff;
      push = 1'b0;
      push_job.chars = seq;
      push_job.last_idx = 2'(n - 3'd1);
      push_job.is_term = 1'b0;
      push_job.stopped = 1'b0;
      push_job.consumed = to_report(cons_sat);
      push_job.emitted = to_report(emit_sat);
      if (req_bus.kind == KIND_FINISH) begin
         push_job.chars = '0;
         push_job.chars[0] = CHAR_NUL;
         push_job.last_idx = 2'd0;
         push_job.is_term = 1'b1;
         push_job.stopped = halted_ff;
         push_job.consumed = to_report(consumed_ff);
         push_job.emitted = to_report(emitted_ff);
      end
      if (accept) begin
         if (req_bus.kind == KIND_FINISH) begin
            push = 1'b1;
            guard_in = 1'b0;
            halted_in = 1'b0;
            emitted_in = '0;
            consumed_in = '0;
         end else if (!halted_ff) begin
            if (fits) begin
               push = 1'b1;
               guard_in = next_guard;
               emitted_in = emit_sat;
               consumed_in = cons_sat;
            end else begin
               halted_in = 1'b1;
            end
         end
      end
   end

   // Capture register writes
   always_comb begin
      limit_in = limit_ff;
      cap_in = cap_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_LIMIT_ENABLE: limit_in = csr_bus.data[0];
            CSR_OUT_CAPACITY: cap_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 1'b0;
         cap_ff <= CAPACITY_RESET;
         guard_ff <= 1'b0;
         halted_ff <= 1'b0;
         emitted_ff <= '0;
         consumed_ff <= '0;
      end else begin
         limit_ff <= limit_in;
         cap_ff <= cap_in;
         guard_ff <= guard_in;
         halted_ff <= halted_in;
         emitted_ff <= emitted_in;
         consumed_ff <= consumed_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/cse_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cse_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire cse_pkg::job_type push_job,
   input  wire logic             pop,
   output logic                  full,
   output logic                  head_valid,
   output cse_pkg::job_type      head_job
);
   import cse_pkg::*;

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   assign full = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Store the job
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### rtl/core/cse_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cse_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire cse_pkg::job_type head_job,
   output logic                  pop,
   cse_rsp_if.source             rsp_bus
);
   import cse_pkg::*;

   logic        valid_ff, valid_in;
   logic [1:0]  idx_ff, idx_in;
   logic [7:0]  char_ff, char_in;
   logic        last_ff, last_in;
   logic        term_ff, term_in;
   logic        stop_ff, stop_in;
   logic [15:0] cons_ff, cons_in;
   logic [15:0] len_ff, len_in;
   logic        load;
   logic        at_last;

   // Step through the head job one character per cycle while the result side is ready
   always_comb begin
      load = !valid_ff || rsp_bus.ready;
      at_last = (idx_ff == head_job.last_idx);
      valid_in = valid_ff;
      idx_in = idx_ff;
      pop = 1'b0;
      char_in = char_ff;
      last_in = last_ff;
      term_in = term_ff;
      stop_in = stop_ff;
      cons_in = cons_ff;
      len_in = len_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            char_in = head_job.chars[idx_ff];
            last_in = at_last;
            term_in = head_job.is_term;
            stop_in = head_job.stopped;
            cons_in = head_job.consumed;
            len_in = head_job.emitted;
            if (at_last) begin
               pop = 1'b1;
               idx_in = 2'd0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
      end
   end

   // Hold the output item
   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      term_ff <= term_in;
      stop_ff <= stop_in;
      cons_ff <= cons_in;
      len_ff <= len_in;
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.out_char = char_ff;
   assign rsp_bus.run_last = last_ff;
   assign rsp_bus.is_terminator = term_ff;
   assign rsp_bus.stopped = stop_ff;
   assign rsp_bus.consumed_count = cons_ff;
   assign rsp_bus.out_length = len_ff;

endmodule

`default_nettype wire

### rtl/core/c_string_escape_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// C string literal escaper. Each data item is one raw byte and yields one to
// four output items, one character each (none once escaping halts): the byte
// itself, a backslash and a letter for named controls, a backslash before
// quote, apostrophe and backslash, or a backslash and 1 to 3 octal digits for
// other non-printing bytes and for digits 0 to 7 right after a short octal
// escape. A finish item yields one terminator item carrying the stopped flag
// and both counts, then clears the string state. With limit_enable set, the
// first byte whose expansion plus the terminator would overrun out_capacity
// halts escaping until finish. The front stage takes one item per cycle into
// a four-entry job queue unless it is full; the back stage sends one character
// per cycle while the result side is ready. Only bytes 0x7f and up take four.
// Write the two registers only while no items are in flight.
module c_string_escape_encoder (
   input  wire logic clock,
   input  wire logic reset,
   cse_req_if.sink   req_bus,
   cse_rsp_if.source rsp_bus,
   cse_csr_if.sink   csr_bus
);
   import cse_pkg::*;

   logic    push;
   job_type push_job;
   logic    pop;
   logic    full;
   logic    head_valid;
   job_type head_job;

   cse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .queue_full (full),
      .push       (push),
      .push_job   (push_job)
   );

   cse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   cse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

### tb/sv/cse_escape_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the escaper, tracks the string state itself,
// and checks every result item against the oldest expected character.
module cse_escape_checker (
   input  wire logic clock,
   input  wire logic reset,
   cse_req_if        req_mon,
   cse_rsp_if        rsp_mon,
   cse_csr_if        csr_mon,
   input  wire logic drain_done,
   output int        mismatch_total,
   output int        pending,
   output int        items_seen,
   output int        chars_seen,
   output int        strings_done,
   output int        halts_seen
);
   import cse_pkg::*;

   typedef struct packed {
      logic [7:0]  ch;
      logic        last;
      logic        term;
      logic        stop;
      logic [15:0] consumed;
      logic [15:0] length;
   } glyph_type;

   glyph_type expected_glyphs[$];

   // Mirror of the block's registers and string state
   logic                  limit_on;
   logic [CAP_BITS-1:0]   capacity;
   logic                  guard_q;
   logic                  halted_q;
   logic [COUNT_BITS-1:0] emitted_q;
   logic [COUNT_BITS-1:0] consumed_q;
   bit                    closed;

   initial begin
      mismatch_total = 0;
      pending = 0;
      items_seen = 0;
      chars_seen = 0;
      strings_done = 0;
      halts_seen = 0;
      closed = 0;
   end

   task automatic note_mismatch(input string what, input int got, input int want);
      mismatch_total++;
      $display("mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
               what, got, want, chars_seen);
   endtask

   function automatic logic [7:0] control_letter(input logic [7:0] b);
      logic [7:0] letter;
      case (b)
         8'h07:   letter = "a";
         8'h08:   letter = "b";
         8'h09:   letter = "t";
         8'h0a:   letter = "n";
         8'h0b:   letter = "v";
         8'h0c:   letter = "f";
         8'h0d:   letter = "r";
         default: letter = 8'h00;
      endcase
      return letter;
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_sum(input logic [COUNT_BITS-1:0] a,
                                                     input int unsigned b);
      logic [COUNT_BITS:0] wide;
      wide = {1'b0, a} + (COUNT_BITS+1)'(b);
      return (wide > {1'b0, COUNT_MAX}) ? COUNT_MAX : wide[COUNT_BITS-1:0];
   endfunction

   task automatic add_glyph(input logic [7:0] ch, input logic last, input logic term,
                            input logic stop);
      glyph_type g;
      g.ch = ch;
      g.last = last;
      g.term = term;
      g.stop = stop;
      g.consumed = 16'(consumed_q);
      g.length = 16'(emitted_q);
      expected_glyphs.insert(expected_glyphs.size(), g);
   endtask

   // Work out the characters that one accepted item produces
   task automatic predict_escape(input logic kind, input logic [7:0] b);
      logic [7:0]          seq [0:3];
      int unsigned         n;
      logic                next_guard;
      logic [7:0]          letter;
      logic [COUNT_BITS:0] need;
      n = 0;
      next_guard = 1'b0;
      if (kind == KIND_FINISH) begin
         add_glyph(CHAR_NUL, 1'b1, 1'b1, halted_q);
         strings_done++;
         guard_q = 1'b0;
         halted_q = 1'b0;
         emitted_q = '0;
         consumed_q = '0;
      end else if (!halted_q) begin
         letter = control_letter(b);
         if (b < CHAR_PRINT_LO || b > CHAR_PRINT_HI
             || (guard_q && b >= CHAR_ZERO && b <= CHAR_SEVEN)) begin
            seq[n] = CHAR_BSLASH;
            n++;
            if (letter != 8'h00) begin
               seq[n] = letter;
               n++;
            end else begin
               // minimal-digit octal; a short one guards the next digit
               if (b[7:6] != 2'd0) begin
                  seq[n] = CHAR_ZERO + 8'(b[7:6]);
                  n++;
               end
               if (b[7:3] != 5'd0) begin
                  seq[n] = CHAR_ZERO + 8'(b[5:3]);
                  n++;
               end
               seq[n] = CHAR_ZERO + 8'(b[2:0]);
               n++;
               next_guard = (b[7:6] == 2'd0);
            end
         end else if (b == CHAR_DQUOTE || b == CHAR_APOS || b == CHAR_BSLASH) begin
            seq[0] = CHAR_BSLASH;
            seq[1] = b;
            n = 2;
         end else begin
            seq[0] = b;
            n = 1;
         end
         // halt when the expansion plus the terminator would not fit
         need = {1'b0, emitted_q} + (COUNT_BITS+1)'(n);
         if (limit_on && need >= (COUNT_BITS+1)'(capacity)) begin
            halted_q = 1'b1;
            halts_seen++;
         end else begin
            guard_q = next_guard;
            emitted_q = sat_sum(emitted_q, n);
            consumed_q = sat_sum(consumed_q, 1);
            for (int k = 0; k < n; k++)
               add_glyph(seq[k], k == n - 1, 1'b0, 1'b0);
         end
      end
   endtask

   always @(posedge clock) begin
      glyph_type want;
      if (reset) begin
         limit_on = 1'b0;
         capacity = CAPACITY_RESET;
         guard_q = 1'b0;
         halted_q = 1'b0;
         emitted_q = '0;
         consumed_q = '0;
         expected_glyphs.delete();
      end else begin
         // register writes
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_LIMIT_ENABLE)
               limit_on = csr_mon.data[0];
            else if (csr_mon.index == CSR_OUT_CAPACITY)
               capacity = csr_mon.data;
         end
         // compare each result item with the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            chars_seen++;
            if (expected_glyphs.size() == 0) begin
               note_mismatch("unexpected result item", rsp_mon.out_char, 0);
            end else begin
               want = expected_glyphs.pop_front();
               if (rsp_mon.out_char !== want.ch)
                  note_mismatch("out_char", rsp_mon.out_char, want.ch);
               if (rsp_mon.run_last !== want.last)
                  note_mismatch("run_last", rsp_mon.run_last, want.last);
               if (rsp_mon.is_terminator !== want.term)
                  note_mismatch("is_terminator", rsp_mon.is_terminator, want.term);
               if (rsp_mon.stopped !== want.stop)
                  note_mismatch("stopped", rsp_mon.stopped, want.stop);
               if (rsp_mon.consumed_count !== want.consumed)
                  note_mismatch("consumed_count", rsp_mon.consumed_count, want.consumed);
               if (rsp_mon.out_length !== want.length)
                  note_mismatch("out_length", rsp_mon.out_length, want.length);
            end
         end
         // predict the items accepted at this edge
         if (req_mon.valid && req_mon.ready) begin
            items_seen++;
            predict_escape(req_mon.kind, req_mon.in_byte);
         end
         if (drain_done && !closed) begin
            closed = 1;
            if (expected_glyphs.size() != 0)
               note_mismatch("expected items never sent", expected_glyphs.size(), 0);
         end
      end
      pending = expected_glyphs.size();
   end

endmodule

### tb/sv/tb_c_string_escape_encoder.sv
`timescale 1ns / 1ps

module tb_c_string_escape_encoder;
   import cse_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = 16;

   logic clock;
   logic reset;
   logic drain_done;
   bit   calm;
   int   rsp_hold_req;
   int   cycle_count;

   int mismatch_total;
   int pending;
   int items_seen;
   int chars_seen;
   int strings_done;
   int halts_seen;

   cse_req_if req_bus ();
   cse_rsp_if rsp_bus ();
   cse_csr_if csr_bus ();

   c_string_escape_encoder i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   cse_escape_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .drain_done     (drain_done),
      .mismatch_total (mismatch_total),
      .pending        (pending),
      .items_seen     (items_seen),
      .chars_seen     (chars_seen),
      .strings_done   (strings_done),
      .halts_seen     (halts_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Bound the run
   initial cycle_count = 0;
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // Result side: random stalls, plus long holds on request
   initial begin
      int stall_left;
      int r;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req > 0) begin
            stall_left = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 12)
               stall_left = $urandom_range(1, 3);
            else if (r < 15)
               stall_left = $urandom_range(10, 40);
            rsp_bus.ready <= (stall_left == 0);
            if (stall_left > 0)
               stall_left--;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // Mix of printable text, digits, controls, quotes and high bytes
   function automatic logic [7:0] pick_byte();
      int r;
      logic [7:0] b;
      r = $urandom_range(0, 99);
      if (r < 30)
         b = 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
      else if (r < 45)
         b = 8'($urandom_range(CHAR_ZERO, CHAR_ZERO + 9));
      else if (r < 58)
         b = 8'($urandom_range(0, CHAR_PRINT_LO - 1));
      else if (r < 66)
         b = 8'($urandom_range(7, 13));
      else if (r < 74) begin
         case ($urandom_range(0, 2))
            0:       b = CHAR_DQUOTE;
            1:       b = CHAR_APOS;
            default: b = CHAR_BSLASH;
         endcase
      end else
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   // Offer one item, hold it until taken, then maybe idle
   task automatic send_item(input logic k, input logic [7:0] b);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.kind <= k;
      req_bus.in_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // Drain, then let a halted item clear the pipeline before a register write
   task automatic quiesce();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic limit_en, input logic [CAP_BITS-1:0] cap);
      quiesce();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_LIMIT_ENABLE;
      csr_bus.data <= 16'(limit_en);
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.index <= CSR_OUT_CAPACITY;
      csr_bus.data <= cap;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Random strings, each closed by a finish, with occasional full drains
   task automatic run_strings(input int budget);
      int sent;
      int len;
      sent = 0;
      while (sent < budget) begin
         len = $urandom_range(0, 12);
         for (int i = 0; i < len; i++) begin
            send_item(KIND_DATA, pick_byte());
            sent++;
            if ($urandom_range(0, 29) == 0)
               wait_drained();
         end
         send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
         sent++;
      end
   endtask

   task automatic config_and_run(input logic limit_en, input logic [CAP_BITS-1:0] cap,
                                 input bit quiet);
      set_config(limit_en, cap);
      calm = quiet;
      run_strings(18);
      calm = 0;
   endtask

   initial begin
      logic [7:0] directed_bytes [0:20];
      directed_bytes = '{
         8'h00, 8'h31,                              // NUL, then a guarded digit
         8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d,
         CHAR_DQUOTE, CHAR_APOS, CHAR_BSLASH,
         CHAR_PRINT_HI, CHAR_PRINT_LO,
         8'h7f, CHAR_ZERO,                          // three digits: no guard
         8'hff, 8'h1f, CHAR_SEVEN,                  // two digits guard a seven
         8'h38, CHAR_ZERO                           // eight clears the guard
      };
      calm = 0;
      rsp_hold_req = 0;
      drain_done = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_DATA;
      req_bus.in_byte = 8'h00;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_LIMIT_ENABLE;
      csr_bus.data = 16'h0000;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Field extremes and every escape form, at the reset settings
      for (int i = 0; i < 21; i++) begin
         send_item(KIND_DATA, directed_bytes[i]);
         if (i == 10)
            wait_drained();
      end
      send_item(KIND_FINISH, 8'hff);

      // Hold the result side while items keep coming to fill the queue
      wait_drained();
      calm = 1;
      rsp_hold_req = 80;
      for (int i = 0; i < 16; i++)
         send_item(KIND_DATA, pick_byte());
      send_item(KIND_FINISH, 8'h00);
      calm = 0;

      // Random strings under several limit settings
      config_and_run(1'b1, 16'($urandom_range(4, 40)), 0);
      config_and_run(1'b1, 16'h0000, 0);
      config_and_run(1'b1, 16'h0001, 0);
      config_and_run(1'b0, 16'h0000, 0);
      config_and_run(1'b1, CAPACITY_RESET, 1);
      config_and_run(1'b1, 16'($urandom_range(2, 20)), 0);

      // Halt, then turn the limit off: bytes stay ignored until finish
      set_config(1'b1, 16'd6);
      repeat (3) send_item(KIND_DATA, 8'hff);
      set_config(1'b0, 16'd6);
      send_item(KIND_DATA, "A");
      send_item(KIND_DATA, "B");
      send_item(KIND_FINISH, 8'h00);
      // Unlimited start, then turn the limit on mid-string
      repeat (10) send_item(KIND_DATA, "x");
      set_config(1'b1, 16'd12);
      send_item(KIND_DATA, "y");
      send_item(KIND_DATA, CHAR_DQUOTE);
      send_item(KIND_DATA, "z");
      send_item(KIND_FINISH, 8'h00);

      // Wind down and give the verdict
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      drain_done <= 1'b1;
      repeat (3) @(posedge clock);
      $display("covered %0d input items in %0d strings, %0d capacity halts, %0d output chars",
               items_seen, strings_done, halts_seen, chars_seen);
      $display("limit on and off, capacities 0, 1, small and 65535, limit toggled mid-string");
      if (mismatch_total == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
